[design/srd_pkg.sv]
package srd_pkg;

	localparam int DATA_W = 32;

	// word accepted from the requester
	typedef struct packed {
		logic signed [DATA_W-1:0] dividend;
		logic signed [DATA_W-1:0] divisor;
	} req_word_t;

	// word handed to the receiver
	typedef struct packed {
		logic signed [DATA_W-1:0] quotient;
		logic signed [DATA_W-1:0] remainder;
	} rsp_word_t;

	// classified job: operand magnitudes and the sign fixes to apply at the end
	typedef struct packed {
		logic [DATA_W-1:0] mag_a;
		logic [DATA_W-1:0] mag_b;
		logic              neg_q;
		logic              neg_r;
	} job_t;

endpackage

[design/srd_front.sv]
module srd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  srd_pkg::req_word_t req,
	output logic              job_valid,
	input  logic              job_ready,
	output srd_pkg::job_t     job
);

	logic          valid_s1;
	srd_pkg::job_t job_s1;
	srd_pkg::job_t job_d;
	logic          sign_a;
	logic          sign_b;

	// magnitudes keep the most negative pattern, read unsigned it is exact
	always_comb begin
		sign_a      = req.dividend[srd_pkg::DATA_W-1];
		sign_b      = req.divisor[srd_pkg::DATA_W-1];
		job_d.mag_a = sign_a ? (~req.dividend + 1'b1) : req.dividend;
		job_d.mag_b = sign_b ? (~req.divisor + 1'b1) : req.divisor;
		job_d.neg_q = sign_a ^ sign_b;
		job_d.neg_r = sign_a;
	end

	assign req_ready = !valid_s1 || job_ready;
	assign job_valid = valid_s1;
	assign job       = job_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			job_s1 <= job_d;
		end
	end

endmodule

[design/srd_queue.sv]
module srd_queue #(
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  srd_pkg::job_t push_job,
	output logic          pop_valid,
	input  logic          pop_ready,
	output srd_pkg::job_t pop_job
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	srd_pkg::job_t  mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           push;
	logic           pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_job    = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

[design/srd_back.sv]
module srd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	output logic               job_ready,
	input  srd_pkg::job_t      job,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output srd_pkg::rsp_word_t rsp
);

	localparam int W = srd_pkg::DATA_W;

	typedef struct packed {
		logic [W-1:0] rem;
		logic [W-1:0] quo;
		logic [W-1:0] div;
		logic         neg_q;
		logic         neg_r;
	} step_t;

	// one restoring step: shift in the next dividend bit, keep the trial if no borrow
	function automatic step_t div_step(step_t s);
		step_t      n;
		logic [W:0]   wide;
		logic [W+1:0] diff;
		logic         keep;
		n    = s;
		wide = {s.rem, s.quo[W-1]};
		diff = {1'b0, wide} - {2'b00, s.div};
		keep = !diff[W+1];
		n.rem = keep ? diff[W-1:0] : wide[W-1:0];
		n.quo = {s.quo[W-2:0], keep};
		return n;
	endfunction

	step_t              pipe_s  [W];
	logic               pipe_vs [W];
	step_t              head;
	logic               en;
	logic               rsp_valid_q;
	srd_pkg::rsp_word_t rsp_q;
	step_t              last;

	// whole step pipe moves together whenever the output register can take a word
	assign en        = !rsp_valid_q || rsp_ready;
	assign job_ready = en;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign last      = pipe_s[W-1];

	always_comb begin
		head.rem   = '0;
		head.quo   = job.mag_a;
		head.div   = job.mag_b;
		head.neg_q = job.neg_q;
		head.neg_r = job.neg_r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < W; k++) begin
				pipe_vs[k] <= 1'b0;
			end
			rsp_valid_q <= 1'b0;
		end else if (en) begin
			pipe_vs[0] <= job_valid;
			for (int k = 1; k < W; k++) begin
				pipe_vs[k] <= pipe_vs[k-1];
			end
			rsp_valid_q <= pipe_vs[W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_s[0] <= div_step(head);
			for (int k = 1; k < W; k++) begin
				pipe_s[k] <= div_step(pipe_s[k-1]);
			end
			rsp_q.quotient  <= last.neg_q ? (~last.quo + 1'b1) : last.quo;
			rsp_q.remainder <= last.neg_r ? (~last.rem + 1'b1) : last.rem;
		end
	end

endmodule

[design/signed_restoring_divider.sv]
// signed restoring divider, one dividend/divisor word in, one quotient/remainder word out
//
// req channel: req_valid/req_ready carry a word of two signed 32-bit operands
// rsp channel: rsp_valid/rsp_ready carry the quotient (truncated toward zero)
//   and the remainder (sign of the dividend); words leave in arrival order
// divide by zero gives an all-ones quotient magnitude, sign-fixed, and the
//   dividend as remainder; the most negative value over minus one wraps
//
// front stage takes magnitudes and sign fixes and hands a job to a small queue
// back end runs one restoring step per pipeline stage, 32 stages, then an
//   output register applies the sign fixes
// throughput: one word per cycle with no stall, set by the one-step-per-stage pipe
// when the receiver stalls, the back pipe freezes with its bubbles; the queue and
//   front register take up to DEPTH + 1 more words, then req_ready drops
// reset clears every valid flag, so req_ready is high once reset is released
module signed_restoring_divider #(
	parameter int DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  srd_pkg::req_word_t req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output srd_pkg::rsp_word_t rsp
);

	// front register to queue
	logic          fq_valid;
	logic          fq_ready;
	srd_pkg::job_t fq_job;

	// queue to step pipe
	logic          qb_valid;
	logic          qb_ready;
	srd_pkg::job_t qb_job;

	srd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.job_valid (fq_valid),
		.job_ready (fq_ready),
		.job       (fq_job)
	);

	// decouples classification from the step pipe so each side stalls alone
	srd_queue #(
		.DEPTH (DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_job   (fq_job),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_job    (qb_job)
	);

	srd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (qb_valid),
		.job_ready (qb_ready),
		.job       (qb_job),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

[design/srd_checker.sv]
module srd_checker #(
	parameter int DEPTH = 2
) (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input srd_pkg::rsp_word_t rsp
);

	// front register, queue, step stages and output register
	localparam int CAP = DEPTH + srd_pkg::DATA_W + 2;
	localparam int OW  = $clog2(CAP + 1);

	logic [OW-1:0] outstanding_q;
	logic          acc_in;
	logic          acc_out;

	assign acc_in  = req_valid && req_ready;
	assign acc_out = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else begin
			case ({acc_in, acc_out})
				2'b10:   outstanding_q <= outstanding_q + 1'b1;
				2'b01:   outstanding_q <= outstanding_q - 1'b1;
				default: outstanding_q <= outstanding_q;
			endcase
		end
	end

	// a stalled result word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result word changed while stalled");

	// no result word without a word in flight
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> outstanding_q != '0)
		else $error("result word with nothing in flight");

	// a full pipe takes nothing more
	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q == OW'(CAP) |-> !req_ready)
		else $error("word accepted beyond capacity");

endmodule

bind signed_restoring_divider srd_checker #(.DEPTH(DEPTH)) u_srd_checker (.*);

[test/signed_restoring_divider_tb.sv]
`timescale 1ns / 100ps

module signed_restoring_divider_tb;

	localparam logic [srd_pkg::DATA_W-1:0] MIN_W = {1'b1, {(srd_pkg::DATA_W-1){1'b0}}};
	localparam logic [srd_pkg::DATA_W-1:0] MAX_W = {1'b0, {(srd_pkg::DATA_W-1){1'b1}}};
	localparam logic [srd_pkg::DATA_W-1:0] ONES  = '1;
	localparam logic [srd_pkg::DATA_W-1:0] ZERO  = '0;

	// random words per idling phase, and the receiver hold-off that fills the pipe
	localparam int PHASE_WORDS = 385;
	localparam int HOLD_CYCLES = 300;
	// settling margin, waited after the last result of a phase
	localparam int SETTLE_CYCLES = 60;
	localparam int N_PHASES = 4;
	localparam int MAX_REPORTS = 10;

	// one row of the directed table: operands, and the result where it is obvious
	typedef struct packed {
		logic [srd_pkg::DATA_W-1:0] a;
		logic [srd_pkg::DATA_W-1:0] b;
		logic                       typed;
		logic [srd_pkg::DATA_W-1:0] q;
		logic [srd_pkg::DATA_W-1:0] r;
	} div_row_t;

	// what the scoreboard holds for each accepted word: the operands and the answer
	typedef struct packed {
		srd_pkg::req_word_t operands;
		srd_pkg::rsp_word_t answer;
	} pending_t;

	localparam int N_DIR = 24;

	div_row_t dir_rows [N_DIR] = '{
		// divide by zero: all-ones magnitude, sign-fixed, remainder is the dividend
		'{ZERO,          ZERO,          1'b1, ONES,          ZERO},
		'{32'h0000_0007, ZERO,          1'b1, ONES,          32'h0000_0007},
		'{32'hffff_fff9, ZERO,          1'b1, 32'h0000_0001, 32'hffff_fff9},
		'{MIN_W,         ZERO,          1'b1, 32'h0000_0001, MIN_W},
		'{MAX_W,         ZERO,          1'b1, ONES,          MAX_W},
		// extreme operands: most negative over minus one wraps back to itself
		'{MIN_W,         ONES,          1'b1, MIN_W,         ZERO},
		'{MIN_W,         32'h0000_0001, 1'b1, MIN_W,         ZERO},
		'{MAX_W,         32'h0000_0001, 1'b1, MAX_W,         ZERO},
		'{MAX_W,         ONES,          1'b1, 32'h8000_0001, ZERO},
		'{MIN_W,         MIN_W,         1'b1, 32'h0000_0001, ZERO},
		'{MAX_W,         MAX_W,         1'b1, 32'h0000_0001, ZERO},
		'{MAX_W,         MIN_W,         1'b1, ZERO,          MAX_W},
		'{MIN_W,         MAX_W,         1'b1, ONES,          ONES},
		// sign combinations: truncation toward zero, remainder follows the dividend
		'{32'h0000_0007, 32'h0000_0002, 1'b1, 32'h0000_0003, 32'h0000_0001},
		'{32'h0000_0007, 32'hffff_fffe, 1'b1, 32'hffff_fffd, 32'h0000_0001},
		'{32'hffff_fff9, 32'h0000_0002, 1'b1, 32'hffff_fffd, ONES},
		'{32'hffff_fff9, 32'hffff_fffe, 1'b1, 32'h0000_0003, ONES},
		'{ZERO,          32'h0000_0005, 1'b1, ZERO,          ZERO},
		'{ONES,          MIN_W,         1'b1, ZERO,          ONES},
		'{ONES,          ONES,          1'b1, 32'h0000_0001, ZERO},
		'{32'h0000_0001, MAX_W,         1'b1, ZERO,          32'h0000_0001},
		'{MIN_W,         32'h0000_0002, 1'b1, 32'hc000_0000, ZERO},
		// ordinary operands, left to the predictor
		'{32'hdead_beef, 32'h0000_1234, 1'b0, ZERO,          ZERO},
		'{32'h1234_5678, 32'hffff_fff9, 1'b0, ZERO,          ZERO}
	};

	logic               clk;
	logic               arst_n;
	logic               req_valid;
	logic               req_ready;
	srd_pkg::req_word_t req;
	logic               rsp_valid;
	logic               rsp_ready;
	srd_pkg::rsp_word_t rsp;

	// typed answer riding along with the offered word, picked up on acceptance
	logic               req_typed;
	srd_pkg::rsp_word_t req_typed_answer;

	pending_t pending_results [$];
	int       bad_results;
	int       reports;

	// idling knobs, percent of cycles, set per phase by the main sequence
	int send_idle;
	int recv_stall;
	bit hold_pending;
	int hold_left;

	signed_restoring_divider uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// expected quotient and remainder of one word, restoring division on magnitudes
	function automatic srd_pkg::rsp_word_t divide_word(srd_pkg::req_word_t w);
		logic [srd_pkg::DATA_W-1:0] a_bits;
		logic [srd_pkg::DATA_W-1:0] b_bits;
		logic [srd_pkg::DATA_W-1:0] num;
		logic [srd_pkg::DATA_W-1:0] den;
		logic [srd_pkg::DATA_W-1:0] quo;
		logic [srd_pkg::DATA_W-1:0] rem;
		logic [srd_pkg::DATA_W:0]   part;
		srd_pkg::rsp_word_t         o;
		a_bits = w.dividend;
		b_bits = w.divisor;
		// the most negative value keeps its pattern, which is its magnitude unsigned
		num = a_bits[srd_pkg::DATA_W-1] ? (~a_bits + 1'b1) : a_bits;
		den = b_bits[srd_pkg::DATA_W-1] ? (~b_bits + 1'b1) : b_bits;
		quo = num;
		part = '0;
		for (int k = 0; k < srd_pkg::DATA_W; k++) begin
			// the partial remainder is one bit wider than the operands
			part = {part[srd_pkg::DATA_W-1:0], quo[srd_pkg::DATA_W-1]};
			quo = quo << 1;
			if (part >= {1'b0, den}) begin
				part = part - {1'b0, den};
				quo[0] = 1'b1;
			end
		end
		rem = part[srd_pkg::DATA_W-1:0];
		o.quotient = (a_bits[srd_pkg::DATA_W-1] != b_bits[srd_pkg::DATA_W-1]) ?
			(~quo + 1'b1) : quo;
		o.remainder = a_bits[srd_pkg::DATA_W-1] ? (~rem + 1'b1) : rem;
		return o;
	endfunction

	// operand mix: extremes, small values, scattered magnitudes, full random
	function automatic logic [srd_pkg::DATA_W-1:0] rand_operand();
		logic [srd_pkg::DATA_W-1:0] v;
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(4))
					0: v = MIN_W;
					1: v = MAX_W;
					2: v = ZERO;
					3: v = 32'h0000_0001;
					default: v = ONES;
				endcase
			end
			1, 2: v = $urandom_range(300);
			3, 4: v = $urandom >> $urandom_range(srd_pkg::DATA_W-1);
			default: v = $urandom;
		endcase
		if ($urandom_range(1))
			v = ~v + 1'b1;
		return v;
	endfunction

	// offer one word, idling first as the phase asks, and return on its accepting edge
	task automatic offer_word(input srd_pkg::req_word_t w, input logic typed,
			input srd_pkg::rsp_word_t answer);
		while ($urandom_range(99) < send_idle) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		req_typed <= typed;
		req_typed_answer <= answer;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
	endtask

	// wait for every expected word, then let the pipe settle
	task automatic drain_results();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// receiver: random stalls, or a long hold-off when the main sequence asks for one
	initial begin
		rsp_ready = 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= ($urandom_range(99) >= recv_stall);
			end
		end
	end

	// scoreboard: sample both handshakes on the edge, values are the pre-edge ones
	always @(posedge clk) begin
		pending_t  head;
		pending_t  entry;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				entry.operands = req;
				entry.answer = req_typed ? req_typed_answer : divide_word(req);
				pending_results.push_back(entry);
			end
			if (rsp_valid && rsp_ready) begin
				if (pending_results.size() == 0) begin
					bad_results++;
					if (reports < MAX_REPORTS) begin
						reports++;
						$display("unexpected word: q=%h r=%h", rsp.quotient, rsp.remainder);
					end
				end else begin
					head = pending_results.pop_front();
					if (rsp.quotient !== head.answer.quotient ||
					    rsp.remainder !== head.answer.remainder) begin
						bad_results++;
						if (reports < MAX_REPORTS) begin
							reports++;
							$display("mismatch %h / %h: expected q=%h r=%h, got q=%h r=%h",
								head.operands.dividend, head.operands.divisor,
								head.answer.quotient, head.answer.remainder,
								rsp.quotient, rsp.remainder);
						end
					end
				end
			end
		end
	end

	// main sequence: reset, directed table, then the random phases
	initial begin
		srd_pkg::req_word_t w;
		srd_pkg::rsp_word_t answer;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		req_typed = 1'b0;
		req_typed_answer = '0;
		bad_results = 0;
		reports = 0;
		send_idle = 0;
		recv_stall = 0;
		hold_pending = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows back to back
		for (int i = 0; i < N_DIR; i++) begin
			w.dividend = dir_rows[i].a;
			w.divisor = dir_rows[i].b;
			answer.quotient = dir_rows[i].q;
			answer.remainder = dir_rows[i].r;
			offer_word(w, dir_rows[i].typed, answer);
		end
		req_valid <= 1'b0;
		drain_results();

		// phases: no idling, sender idle, receiver stalling, both
		for (int p = 0; p < N_PHASES; p++) begin
			case (p)
				0: begin
					send_idle = 0;
					recv_stall = 0;
					// receiver holds off while words keep coming, so req_ready drops
					hold_pending = 1'b1;
				end
				1: begin
					send_idle = 79;
					recv_stall = 0;
				end
				2: begin
					send_idle = 0;
					recv_stall = 79;
				end
				default: begin
					send_idle = 18;
					recv_stall = 18;
				end
			endcase
			for (int n = 0; n < PHASE_WORDS; n++) begin
				w.dividend = rand_operand();
				w.divisor = rand_operand();
				offer_word(w, 1'b0, '0);
			end
			req_valid <= 1'b0;
			drain_results();
		end

		if (bad_results == 0 && pending_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// guard against a hung handshake
	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
